### design/ssc_pkg.sv
package ssc_pkg;

  // problem dimensions
  localparam int NumStates  = 7;
  localparam int NumInputs  = 4;
  localparam int NumOutputs = 2;

  // field widths
  localparam int InW    = 24;
  localparam int DataW  = 32;
  localparam int CoefW  = 32;
  localparam int ProdW  = 64;
  localparam int ShiftW = 20;   // Q.36 sum down to Q.16

  // one coefficient row per output and per state, columns are states then inputs
  localparam int NumRows = NumOutputs + NumStates;
  localparam int NumCols = NumStates + NumInputs;
  localparam int NumCoef = NumRows * NumCols;

  localparam int RowW     = ($clog2(NumRows) > 0) ? $clog2(NumRows) : 1;
  localparam int ColW     = ($clog2(NumCols) > 0) ? $clog2(NumCols) : 1;
  localparam int IdxW     = ($clog2(NumCoef) > 0) ? $clog2(NumCoef) : 1;
  localparam int StIdxW   = ($clog2(NumStates) > 0) ? $clog2(NumStates) : 1;
  localparam int InIdxW   = ($clog2(NumInputs) > 0) ? $clog2(NumInputs) : 1;
  localparam int OutIdxW  = ($clog2(NumOutputs) > 0) ? $clog2(NumOutputs) : 1;

  typedef logic signed [CoefW-1:0] coef_tab_t [NumCoef];

  // coefficients in units of 1e-4, row by row
  localparam int DecTab [NumCoef] = '{
    // output row 0: C then D
    -1901687, 28847, -181579, 6946679, 485009, 341265, 8031,
    139269, 4790, 139043, 4791,
    // output row 1
    279, -514655, 3180072, 6822, -8530362, 251, 41464,
    143, -87620, 139, -87596,
    // state rows: A then B
    3166, 5, -33, 24029, 92, 1178, 25,          478, 2, 480, 2,
    1, 9512, 3681, 6, -9006, 0, -64,            0, -72, 0, -72,
    0, 360, 5546, -7, 9639, 0, 9,               0, 88, 0, 88,
    0, 0, 0, 9992, 0, 0, 0,                     400, 0, 400, 0,
    0, 0, 0, 0, 9998, 0, 0,                     0, 200, 0, 200,
    -24926, 378, -2380, 91051, 6357, -5527, 105, 1825, 63, 1822, 63,
    9, -16864, 104202, 224, -279516, 8, -8641,  5, -2871, 5, -2870
  };

  // scale to Q11.20, round half away from zero
  function automatic coef_tab_t build_coef_tab();
    coef_tab_t tab;
    longint    n;
    for (int i = 0; i < NumCoef; i++) begin
      n      = longint'(DecTab[i]);
      tab[i] = CoefW'((n * 64'sd1048576 + ((n < 0) ? -64'sd5000 : 64'sd5000)) / 64'sd10000);
    end
    return tab;
  endfunction

  localparam coef_tab_t CoefTab = build_coef_tab();

  typedef enum logic [1:0] {
    SeqIdle,
    SeqRun,
    SeqDrain,
    SeqCommit
  } seq_state_e;

  // one multiply-accumulate issue
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [IdxW-1:0] idx;
  } issue_t;

  // finished row leaving the mac
  typedef struct packed {
    logic            valid;
    logic [RowW-1:0] row;
  } wb_t;

  typedef struct packed {
    logic idle;
    logic commit;
  } seq_status_t;

endpackage

### design/ssc_mac.sv
module ssc_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ssc_pkg::issue_t                      issue_i,
  input  logic signed [ssc_pkg::DataW-1:0]     op_i,
  output ssc_pkg::wb_t                         wb_o,
  output logic signed [ssc_pkg::DataW-1:0]     wb_data_o
);

  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    logic [ssc_pkg::RowW-1:0] row;
  } ctl_t;

  localparam int ShrW = ssc_pkg::ProdW - ssc_pkg::ShiftW;

  // clamp limits at the width of the shifted sum
  localparam logic signed [ShrW-1:0] SatHi = ShrW'({1'b0, {(ssc_pkg::DataW-1){1'b1}}});
  localparam logic signed [ShrW-1:0] SatLo = ~SatHi;

  ctl_t                                ctl1_q, ctl2_q;
  logic signed [ssc_pkg::DataW-1:0]    op1_q;
  logic signed [ssc_pkg::CoefW-1:0]    coef1_q;
  logic signed [ssc_pkg::ProdW-1:0]    prod2_q;
  logic signed [ssc_pkg::ProdW-1:0]    acc_q, acc_d;
  logic                                last3_q;
  logic [ssc_pkg::RowW-1:0]            row3_q;
  logic                                wb_valid_q;
  logic [ssc_pkg::RowW-1:0]            wb_row_q;
  logic signed [ssc_pkg::DataW-1:0]    res_q, res_d;
  logic signed [ssc_pkg::ProdW-1:0]    rnd;
  logic signed [ShrW-1:0]              shr;

  // operand and coefficient fetch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else begin
      ctl1_q <= '{valid: issue_i.valid, first: issue_i.first, last: issue_i.last,
                  row: issue_i.row};
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_i;
    coef1_q <= ssc_pkg::CoefTab[issue_i.idx];
  end

  // product, exact at q.36
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else begin
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod2_q <= ssc_pkg::ProdW'(op1_q) * ssc_pkg::ProdW'(coef1_q);
  end

  // accumulate
  always_comb begin
    acc_d = acc_q;
    if (ctl2_q.valid) begin
      acc_d = ctl2_q.first ? prod2_q : acc_q + prod2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last3_q <= 1'b0;
    end else begin
      last3_q <= ctl2_q.valid & ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    row3_q <= ctl2_q.row;
  end

  // round half up to q.16 and clamp
  always_comb begin
    rnd = acc_q + (ssc_pkg::ProdW'(1) <<< (ssc_pkg::ShiftW - 1));
    shr = rnd[ssc_pkg::ProdW-1:ssc_pkg::ShiftW];
    if (shr > SatHi) begin
      res_d = {1'b0, {(ssc_pkg::DataW-1){1'b1}}};
    end else if (shr < SatLo) begin
      res_d = {1'b1, {(ssc_pkg::DataW-1){1'b0}}};
    end else begin
      res_d = shr[ssc_pkg::DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= last3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_row_q <= row3_q;
    res_q    <= res_d;
  end

  assign wb_o      = '{valid: wb_valid_q, row: wb_row_q};
  assign wb_data_o = res_q;

endmodule

### design/ssc_seq.sv
module ssc_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ssc_pkg::wb_t         wb_i,
  output ssc_pkg::issue_t      issue_o,
  output ssc_pkg::seq_status_t status_o
);

  ssc_pkg::seq_state_e state_q, state_d;
  logic [ssc_pkg::RowW-1:0] row_q, row_d;
  logic [ssc_pkg::ColW-1:0] col_q, col_d;
  logic [ssc_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     col_end;

  assign col_end = (col_q == ssc_pkg::ColW'(ssc_pkg::NumCols - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssc_pkg::SeqIdle;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    idx_d    = idx_q;
    issue_o  = '{valid: 1'b0, first: (col_q == '0), last: col_end, row: row_q,
                 col: col_q, idx: idx_q};
    status_o = '{idle: 1'b0, commit: 1'b0};
    unique case (state_q)
      ssc_pkg::SeqIdle: begin
        status_o.idle = 1'b1;
        row_d = '0;
        col_d = '0;
        idx_d = '0;
        if (start_i) begin
          state_d = ssc_pkg::SeqRun;
        end
      end
      ssc_pkg::SeqRun: begin
        issue_o.valid = 1'b1;
        idx_d = idx_q + 1'b1;
        if (col_end) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        if (idx_q == ssc_pkg::IdxW'(ssc_pkg::NumCoef - 1)) begin
          state_d = ssc_pkg::SeqDrain;
        end
      end
      ssc_pkg::SeqDrain: begin
        if (wb_i.valid && wb_i.row == ssc_pkg::RowW'(ssc_pkg::NumRows - 1)) begin
          state_d = ssc_pkg::SeqCommit;
        end
      end
      ssc_pkg::SeqCommit: begin
        status_o.commit = 1'b1;
        state_d = ssc_pkg::SeqIdle;
      end
      default: begin
        state_d = ssc_pkg::SeqIdle;
      end
    endcase
  end

endmodule

### design/state_space_controller_step.sv
// channel   | dir | fields of tdata, lowest bit up
// s_axis    | in  | surge_ref, yaw_rate_ref, surge_meas, yaw_rate_meas (4 x 24 bit, Q7.16)
// m_axis    | out | common_mode, differential_mode (2 x 32 bit, Q15.16)
//
// for each item, every coefficient of the 9 x 11 table goes once
// through the single 32 x 32 multiply-accumulate unit, then its
// four-stage pipeline drains, the new state is committed and the block
// goes back to idle, where it can take the next item.
// reset clears the state vector and all handshake control.
// s_axis_tready is low while an item is being worked on, or while a result
// is still held and not being taken in the same cycle.
module state_space_controller_step (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // surge_ref, yaw_rate_ref, surge_meas, yaw_rate_meas
  input  logic [ssc_pkg::NumInputs*ssc_pkg::InW-1:0]    s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // common_mode, differential_mode
  output logic [ssc_pkg::NumOutputs*ssc_pkg::DataW-1:0] m_axis_tdata
);

  logic                                                 in_accept;
  ssc_pkg::issue_t                                      issue;
  ssc_pkg::seq_status_t                                 status;
  ssc_pkg::wb_t                                         wb;
  logic signed [ssc_pkg::DataW-1:0]                     wb_data;
  logic signed [ssc_pkg::DataW-1:0]                     operand;

  // sample held for the whole item
  logic [ssc_pkg::NumInputs-1:0][ssc_pkg::InW-1:0]      u_q;
  // state before and after the update
  logic [ssc_pkg::NumStates-1:0][ssc_pkg::DataW-1:0]    state_q, state_d;
  logic [ssc_pkg::NumStates-1:0][ssc_pkg::DataW-1:0]    nxt_q;
  // result register
  logic [ssc_pkg::NumOutputs-1:0][ssc_pkg::DataW-1:0]   out_q;
  logic                                                 out_valid_q, out_valid_d;

  // accept only when idle and the result slot is free by the next edge
  assign s_axis_tready = status.idle & (~out_valid_q | m_axis_tready);
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  ssc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .wb_i     (wb),
    .issue_o  (issue),
    .status_o (status)
  );

  // operand select: state columns first, then the sign-extended sample
  always_comb begin
    if (issue.col < ssc_pkg::ColW'(ssc_pkg::NumStates)) begin
      operand = state_q[issue.col[ssc_pkg::StIdxW-1:0]];
    end else begin
      operand = ssc_pkg::DataW'($signed(
        u_q[ssc_pkg::InIdxW'(issue.col - ssc_pkg::ColW'(ssc_pkg::NumStates))]));
    end
  end

  ssc_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .op_i      (operand),
    .wb_o      (wb),
    .wb_data_o (wb_data)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      u_q <= s_axis_tdata;
    end
  end

  // finished rows: outputs go to the result register, states to the shadow copy
  always_ff @(posedge clk_i) begin
    if (wb.valid) begin
      if (wb.row < ssc_pkg::RowW'(ssc_pkg::NumOutputs)) begin
        out_q[wb.row[ssc_pkg::OutIdxW-1:0]] <= wb_data;
      end else begin
        nxt_q[ssc_pkg::StIdxW'(wb.row - ssc_pkg::RowW'(ssc_pkg::NumOutputs))] <= wb_data;
      end
    end
  end

  // new state takes effect only once every row has used the old one
  assign state_d = status.commit ? nxt_q : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (wb.valid && wb.row == ssc_pkg::RowW'(ssc_pkg::NumOutputs - 1)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // a result only appears when the last output row is written back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      $past(wb.valid && wb.row == ssc_pkg::RowW'(ssc_pkg::NumOutputs - 1)))
    else $error("result raised without its last output row");

  // the block is busy straight after taking an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("item accepted while still working");

  // no writeback while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.idle |-> !wb.valid)
    else $error("writeback outside an item");

  // state only changes at commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(status.commit) |-> $stable(state_q))
    else $error("state changed outside commit");

  // the result slot is never overwritten while still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |->
      !(wb.valid && wb.row < ssc_pkg::RowW'(ssc_pkg::NumOutputs)))
    else $error("held result overwritten");

endmodule
